@@ src/load_stepped_frequency_governor_unit_assert.svh @@
// Assertion macros for the load-stepped frequency governor.
// Included by the top level; needs a clock and an active-low reset name.
`ifndef LOAD_STEPPED_FREQUENCY_GOVERNOR_UNIT_ASSERT_SVH
`define LOAD_STEPPED_FREQUENCY_GOVERNOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LSFG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSFG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lsfg_pkg.sv @@
// Shared types and constants of the load-stepped frequency governor.
// No dependencies; used by the channel interfaces and the top level.
package lsfg_pkg;

    localparam int FREQ_W   = 23;
    localparam int CNT_W    = 32;
    localparam int PCT_W    = 7;
    localparam int FACTOR_W = 4;
    localparam int UPWIN_W  = 16;
    localparam int DNWIN_W  = 20;
    localparam int APB_A_W  = 5;
    localparam int APB_D_W  = 32;
    localparam int UPLIM_W  = PCT_W + UPWIN_W;
    localparam int DNLIM_W  = PCT_W + DNWIN_W;

    localparam logic [FREQ_W-1:0] STEP_DOWN_KHZ = 23'd160000;
    localparam logic [FREQ_W-1:0] SLEEP_MAX_KHZ = 23'd320000;
    localparam logic [FREQ_W-1:0] AWAKE_MIN_KHZ = 23'd480000;
    localparam logic [FREQ_W-1:0] MIN_STEP_KHZ  = 23'd5;
    localparam logic [PCT_W-1:0]  FULL_PCT      = 7'd100;

    // floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for every 23-bit x
    localparam logic [FREQ_W-1:0] DIV5_MUL   = 23'd6710887;
    localparam int                DIV5_SHIFT = 25;

    localparam logic [PCT_W-1:0]    RST_UP_THR  = 7'd50;
    localparam logic [PCT_W-1:0]    RST_DN_THR  = 7'd15;
    localparam logic [FACTOR_W-1:0] RST_FACTOR  = 4'd4;
    localparam logic [UPWIN_W-1:0]  RST_UP_WIN  = 16'd20;
    localparam logic [DNWIN_W-1:0]  RST_DN_WIN  = 20'd80;
    localparam logic [FREQ_W-1:0]   RST_FMAX    = 23'd1000000;
    localparam logic [FREQ_W-1:0]   RST_FMIN    = 23'd245000;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_NOTICE = 2'd1,
        ACT_START  = 2'd2,
        ACT_STOP   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_UP_THR     = 3'd0,
        REG_DN_THR     = 3'd1,
        REG_DN_FACTOR  = 3'd2,
        REG_UP_WIN     = 3'd3,
        REG_DN_WIN     = 3'd4,
        REG_FMAX       = 3'd5,
        REG_FMIN       = 3'd6,
        REG_COUNT_NICE = 3'd7
    } t_reg_idx;

    function automatic logic [PCT_W-1:0] headroom(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] h;
        h = (pct >= FULL_PCT) ? '0 : FULL_PCT - pct;
        return h;
    endfunction

endpackage

@@ src/lsfg_in_if.sv @@
// Input item channel of the load-stepped frequency governor.
// Depends on lsfg_pkg for field types.
interface lsfg_in_if;
    logic                         valid;
    logic                         ready;
    lsfg_pkg::t_action            action;
    logic [lsfg_pkg::CNT_W-1:0]   idle_count;
    logic [lsfg_pkg::CNT_W-1:0]   iowait_count;
    logic [lsfg_pkg::CNT_W-1:0]   nice_count;
    logic                         sleep_mode;
    logic [lsfg_pkg::FREQ_W-1:0]  freq_khz;

    modport source (output valid, action, idle_count, iowait_count, nice_count,
                    sleep_mode, freq_khz, input ready);
    modport sink   (input valid, action, idle_count, iowait_count, nice_count,
                    sleep_mode, freq_khz, output ready);
endinterface

@@ src/lsfg_out_if.sv @@
// Result item channel of the load-stepped frequency governor.
// Depends on lsfg_pkg for field widths.
interface lsfg_out_if;
    logic                         valid;
    logic                         ready;
    logic [lsfg_pkg::FREQ_W-1:0]  target_khz;
    logic                         went_up;

    modport source (output valid, target_khz, went_up, input ready);
    modport sink   (input valid, target_khz, went_up, output ready);
endinterface

@@ src/load_stepped_frequency_governor_unit.sv @@
// Top level of the load-stepped frequency governor: APB registers, input
// register, decision logic and result register.
// Depends on lsfg_pkg, lsfg_in_if, lsfg_out_if and the assertion macro header.
//
// Usage:
//   i_in carries one item per sample tick, frequency notice, start or stop.
//   o_out carries a target frequency and direction for each up or down
//   decision; other items produce no result.
//   The user must write configuration over the APB port only while no item
//   is in flight; the block does not enforce this.
// Path: an accepted item is held in the input register; once it advances,
//   the result register holds the decision.
// Throughput: one item per cycle unless a result waits on low o_out.ready;
//   the decision logic from input to result register is one pass of adds,
//   constant multiplies and compares against limits precomputed from config.
// Reset: i_rst_n is synchronous; it restores default configuration, clears
//   the enable, the idle baselines, the skip count and the request, and
//   empties both registers.
// Stall: while o_out.ready is low and a result waits, the input register
//   holds one more item and i_in.ready drops once that register is full.
`include "load_stepped_frequency_governor_unit_assert.svh"

module load_stepped_frequency_governor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lsfg_in_if.sink                           i_in,
    lsfg_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsfg_pkg::APB_A_W-1:0]      paddr,
    input  logic [lsfg_pkg::APB_D_W-1:0]      pwdata,
    output logic [lsfg_pkg::APB_D_W-1:0]      prdata,
    output logic                              pready
);

    // configuration
    logic [lsfg_pkg::PCT_W-1:0]    r_up_thr;
    logic [lsfg_pkg::PCT_W-1:0]    r_dn_thr;
    logic [lsfg_pkg::FACTOR_W-1:0] r_factor;
    logic [lsfg_pkg::UPWIN_W-1:0]  r_up_win;
    logic [lsfg_pkg::DNWIN_W-1:0]  r_dn_win;
    logic [lsfg_pkg::FREQ_W-1:0]   r_fmax;
    logic [lsfg_pkg::FREQ_W-1:0]   r_fmin;
    logic                          r_count_nice;

    // derived from configuration
    logic [lsfg_pkg::UPLIM_W-1:0]  r_up_lim;
    logic [lsfg_pkg::DNLIM_W-1:0]  r_dn_lim;
    logic [lsfg_pkg::FREQ_W-1:0]   r_step_awake;
    logic [lsfg_pkg::FREQ_W-1:0]   r_step_sleep;

    // governor state
    logic                          r_en;
    logic [lsfg_pkg::CNT_W-1:0]    r_last_up;
    logic [lsfg_pkg::CNT_W-1:0]    r_last_dn;
    logic [lsfg_pkg::FACTOR_W-1:0] r_skip;
    logic [lsfg_pkg::FREQ_W-1:0]   r_req;

    // input register
    logic                          r_in_vld;
    lsfg_pkg::t_action             r_in_action;
    logic [lsfg_pkg::CNT_W-1:0]    r_in_idle;
    logic [lsfg_pkg::CNT_W-1:0]    r_in_iow;
    logic [lsfg_pkg::CNT_W-1:0]    r_in_nice;
    logic                          r_in_sleep;
    logic [lsfg_pkg::FREQ_W-1:0]   r_in_freq;

    // result register
    logic                          r_out_vld;
    logic [lsfg_pkg::FREQ_W-1:0]   r_out_target;
    logic                          r_out_up;

    logic                          cfg_wr;
    lsfg_pkg::t_reg_idx            cfg_idx;
    logic                          in_acc;
    logic                          adv;

    logic [2*lsfg_pkg::FREQ_W-1:0] div5_prod;
    logic [lsfg_pkg::FREQ_W-1:0]   div5_q;

    logic [lsfg_pkg::CNT_W-1:0]    total;
    logic [lsfg_pkg::CNT_W-1:0]    delta;
    logic [lsfg_pkg::CNT_W-1:0]    delta2;
    logic [lsfg_pkg::CNT_W+6:0]    delta_x100;
    logic [lsfg_pkg::CNT_W+13:0]   delta_x10000;
    logic [lsfg_pkg::CNT_W+6:0]    delta2_x100;
    logic                          up_hit;
    logic                          dn_hit;
    logic [lsfg_pkg::FACTOR_W-1:0] skip_inc;

    logic [lsfg_pkg::FREQ_W:0]     up_sum;
    logic [lsfg_pkg::FREQ_W-1:0]   up_clamp;
    logic [lsfg_pkg::FREQ_W-1:0]   up_val;
    logic [lsfg_pkg::FREQ_W-1:0]   dn_base;
    logic [lsfg_pkg::FREQ_W-1:0]   dn_clamp;
    logic [lsfg_pkg::FREQ_W-1:0]   dn_val;

    logic                          n_en;
    logic [lsfg_pkg::CNT_W-1:0]    n_last_up;
    logic [lsfg_pkg::CNT_W-1:0]    n_last_dn;
    logic [lsfg_pkg::FACTOR_W-1:0] n_skip;
    logic [lsfg_pkg::FREQ_W-1:0]   n_req;
    logic                          n_emit;
    logic                          n_up;

    // APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = lsfg_pkg::t_reg_idx'(paddr[4:2]);

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            lsfg_pkg::REG_UP_THR:     prdata = 32'(r_up_thr);
            lsfg_pkg::REG_DN_THR:     prdata = 32'(r_dn_thr);
            lsfg_pkg::REG_DN_FACTOR:  prdata = 32'(r_factor);
            lsfg_pkg::REG_UP_WIN:     prdata = 32'(r_up_win);
            lsfg_pkg::REG_DN_WIN:     prdata = 32'(r_dn_win);
            lsfg_pkg::REG_FMAX:       prdata = 32'(r_fmax);
            lsfg_pkg::REG_FMIN:       prdata = 32'(r_fmin);
            lsfg_pkg::REG_COUNT_NICE: prdata = 32'(r_count_nice);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_thr     <= lsfg_pkg::RST_UP_THR;
            r_dn_thr     <= lsfg_pkg::RST_DN_THR;
            r_factor     <= lsfg_pkg::RST_FACTOR;
            r_up_win     <= lsfg_pkg::RST_UP_WIN;
            r_dn_win     <= lsfg_pkg::RST_DN_WIN;
            r_fmax       <= lsfg_pkg::RST_FMAX;
            r_fmin       <= lsfg_pkg::RST_FMIN;
            r_count_nice <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                lsfg_pkg::REG_UP_THR:     r_up_thr     <= pwdata[lsfg_pkg::PCT_W-1:0];
                lsfg_pkg::REG_DN_THR:     r_dn_thr     <= pwdata[lsfg_pkg::PCT_W-1:0];
                lsfg_pkg::REG_DN_FACTOR:  r_factor     <= pwdata[lsfg_pkg::FACTOR_W-1:0];
                lsfg_pkg::REG_UP_WIN:     r_up_win     <= pwdata[lsfg_pkg::UPWIN_W-1:0];
                lsfg_pkg::REG_DN_WIN:     r_dn_win     <= pwdata[lsfg_pkg::DNWIN_W-1:0];
                lsfg_pkg::REG_FMAX:       r_fmax       <= pwdata[lsfg_pkg::FREQ_W-1:0];
                lsfg_pkg::REG_FMIN:       r_fmin       <= pwdata[lsfg_pkg::FREQ_W-1:0];
                lsfg_pkg::REG_COUNT_NICE: r_count_nice <= pwdata[0];
            endcase
        end
    end

    // limits and up steps, refreshed every cycle from configuration
    assign div5_prod = (2*lsfg_pkg::FREQ_W)'(r_fmax)
                       * (2*lsfg_pkg::FREQ_W)'(lsfg_pkg::DIV5_MUL);
    assign div5_q    = lsfg_pkg::FREQ_W'(
                           div5_prod[2*lsfg_pkg::FREQ_W-1:lsfg_pkg::DIV5_SHIFT]);

    always_ff @(posedge i_clk) begin
        r_up_lim     <= lsfg_pkg::UPLIM_W'(lsfg_pkg::headroom(r_up_thr))
                        * lsfg_pkg::UPLIM_W'(r_up_win);
        r_dn_lim     <= lsfg_pkg::DNLIM_W'(lsfg_pkg::headroom(r_dn_thr))
                        * lsfg_pkg::DNLIM_W'(r_dn_win);
        r_step_awake <= (r_fmax == '0) ? lsfg_pkg::MIN_STEP_KHZ : r_fmax;
        r_step_sleep <= (div5_q == '0) ? lsfg_pkg::MIN_STEP_KHZ : div5_q;
    end

    // handshake
    assign adv        = r_in_vld & (~r_out_vld | o_out.ready);
    assign i_in.ready = ~r_in_vld | adv;
    assign in_acc     = i_in.valid & i_in.ready;

    assign o_out.valid      = r_out_vld;
    assign o_out.target_khz = r_out_target;
    assign o_out.went_up    = r_out_up;

    // idle arithmetic
    assign total  = r_in_idle + r_in_iow + (r_count_nice ? r_in_nice : '0);
    assign delta  = total - r_last_up;
    assign delta2 = total - r_last_dn;

    assign delta_x100   = (lsfg_pkg::CNT_W+7)'(delta) * (lsfg_pkg::CNT_W+7)'(100);
    assign delta_x10000 = (lsfg_pkg::CNT_W+14)'(delta) * (lsfg_pkg::CNT_W+14)'(10000);
    assign delta2_x100  = (lsfg_pkg::CNT_W+7)'(delta2) * (lsfg_pkg::CNT_W+7)'(100);

    assign up_hit   = delta_x100 < (lsfg_pkg::CNT_W+7)'(r_up_lim);
    // min(delta * 100, delta2) * 100 > lim <=> delta_x10000, delta2_x100 > lim
    assign dn_hit   = (delta_x10000 > (lsfg_pkg::CNT_W+14)'(r_dn_lim)) &&
                      (delta2_x100 > (lsfg_pkg::CNT_W+7)'(r_dn_lim));
    assign skip_inc = r_skip + 1'b1;

    // up target
    always_comb begin
        up_sum   = {1'b0, r_req} + {1'b0, (r_in_sleep ? r_step_sleep : r_step_awake)};
        up_clamp = (up_sum > {1'b0, r_fmax}) ? r_fmax : up_sum[lsfg_pkg::FREQ_W-1:0];
        if (r_in_sleep) begin
            up_val = (up_clamp > lsfg_pkg::SLEEP_MAX_KHZ) ? lsfg_pkg::SLEEP_MAX_KHZ : up_clamp;
        end else begin
            up_val = (up_clamp < lsfg_pkg::AWAKE_MIN_KHZ) ? lsfg_pkg::AWAKE_MIN_KHZ : up_clamp;
        end
    end

    // down target
    always_comb begin
        dn_base  = (r_req < lsfg_pkg::STEP_DOWN_KHZ) ? r_fmin
                                                     : r_req - lsfg_pkg::STEP_DOWN_KHZ;
        dn_clamp = (dn_base < r_fmin) ? r_fmin : dn_base;
        if (r_in_sleep) begin
            dn_val = (dn_clamp > lsfg_pkg::SLEEP_MAX_KHZ) ? lsfg_pkg::SLEEP_MAX_KHZ : dn_clamp;
        end else begin
            dn_val = (dn_clamp < lsfg_pkg::AWAKE_MIN_KHZ) ? lsfg_pkg::AWAKE_MIN_KHZ : dn_clamp;
        end
    end

    // decision
    always_comb begin
        n_en      = r_en;
        n_last_up = r_last_up;
        n_last_dn = r_last_dn;
        n_skip    = r_skip;
        n_req     = r_req;
        n_emit    = 1'b0;
        n_up      = 1'b0;
        if (adv) begin
            case (r_in_action)
                lsfg_pkg::ACT_START: begin
                    if (!r_en && r_in_freq != '0) begin
                        n_en      = 1'b1;
                        n_last_up = total;
                        n_last_dn = total;
                        n_skip    = '0;
                        n_req     = r_in_freq;
                    end
                end
                lsfg_pkg::ACT_STOP: begin
                    n_en = 1'b0;
                end
                lsfg_pkg::ACT_NOTICE: begin
                    if (r_en) begin
                        n_req = r_in_freq;
                    end
                end
                default: begin
                    if (r_en) begin
                        n_last_up = total;
                        if (up_hit) begin
                            n_skip    = '0;
                            n_last_dn = total;
                            if (r_req != r_fmax || r_in_sleep) begin
                                n_req  = up_val;
                                n_emit = 1'b1;
                                n_up   = 1'b1;
                            end
                        end else if (skip_inc < r_factor) begin
                            n_skip = skip_inc;
                        end else begin
                            n_skip    = '0;
                            n_last_dn = total;
                            if (dn_hit && !(r_req == r_fmin && r_in_sleep)) begin
                                n_req  = dn_val;
                                n_emit = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // state, input register, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_last_up <= '0;
            r_last_dn <= '0;
            r_skip    <= '0;
            r_req     <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_en      <= n_en;
            r_last_up <= n_last_up;
            r_last_dn <= n_last_dn;
            r_skip    <= n_skip;
            r_req     <= n_req;
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= n_emit;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_action <= i_in.action;
            r_in_idle   <= i_in.idle_count;
            r_in_iow    <= i_in.iowait_count;
            r_in_nice   <= i_in.nice_count;
            r_in_sleep  <= i_in.sleep_mode;
            r_in_freq   <= i_in.freq_khz;
        end
        if (adv && n_emit) begin
            r_out_target <= n_req;
            r_out_up     <= n_up;
        end
    end

    `LSFG_ASSERT_NEXT(a_item_held, i_clk, i_rst_n, r_in_vld && !adv, r_in_vld,
        "pending item dropped from input register")
    `LSFG_ASSERT_SAME(a_emit_sample, i_clk, i_rst_n, n_emit,
        adv && r_en && r_in_action == lsfg_pkg::ACT_SAMPLE,
        "result raised by an item other than an enabled sample")
    `LSFG_ASSERT_NEXT(a_start_arms, i_clk, i_rst_n,
        adv && !r_en && r_in_action == lsfg_pkg::ACT_START && r_in_freq != '0,
        r_en && r_skip == '0 && r_req == $past(r_in_freq),
        "start did not arm the governor")
    `LSFG_ASSERT_SAME(a_sleep_cap, i_clk, i_rst_n, adv && n_emit && r_in_sleep,
        n_req <= lsfg_pkg::SLEEP_MAX_KHZ,
        "sleep target above sleep cap")

endmodule

@@ verif/tb.sv @@
// Testbench for load_stepped_frequency_governor_unit: directed and random items, APB setup.
// Predicts each target and checks every result item in order.
// Depends on lsfg_pkg, lsfg_in_if, lsfg_out_if and the top level in src.
module tb;

    typedef struct packed {
        logic [lsfg_pkg::FREQ_W-1:0] target_khz;
        logic                        went_up;
    } t_target_item;

    class t_freq_target_board;
        logic [lsfg_pkg::PCT_W-1:0]    up_thr;
        logic [lsfg_pkg::PCT_W-1:0]    dn_thr;
        logic [lsfg_pkg::FACTOR_W-1:0] down_factor;
        logic [lsfg_pkg::UPWIN_W-1:0]  up_win;
        logic [lsfg_pkg::DNWIN_W-1:0]  dn_win;
        logic [lsfg_pkg::FREQ_W-1:0]   fmax;
        logic [lsfg_pkg::FREQ_W-1:0]   fmin;
        logic                          count_nice;
        logic                          enabled;
        logic [lsfg_pkg::CNT_W-1:0]    base_up;
        logic [lsfg_pkg::CNT_W-1:0]    base_down;
        logic [lsfg_pkg::FACTOR_W-1:0] skip;
        logic [lsfg_pkg::FREQ_W-1:0]   requested;
        t_target_item                  pending_targets[$];
        int                            mismatch_count;

        function new();
            up_thr         = lsfg_pkg::RST_UP_THR;
            dn_thr         = lsfg_pkg::RST_DN_THR;
            down_factor    = lsfg_pkg::RST_FACTOR;
            up_win         = lsfg_pkg::RST_UP_WIN;
            dn_win         = lsfg_pkg::RST_DN_WIN;
            fmax           = lsfg_pkg::RST_FMAX;
            fmin           = lsfg_pkg::RST_FMIN;
            count_nice     = 1'b1;
            enabled        = 1'b0;
            base_up        = '0;
            base_down      = '0;
            skip           = '0;
            requested      = '0;
            mismatch_count = 0;
        endfunction

        function logic [63:0] margin(logic [lsfg_pkg::PCT_W-1:0] pct);
            return (pct >= lsfg_pkg::FULL_PCT) ? 64'd0 : 64'(lsfg_pkg::FULL_PCT - pct);
        endfunction

        function void set_register(lsfg_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                lsfg_pkg::REG_UP_THR:     up_thr = value[lsfg_pkg::PCT_W-1:0];
                lsfg_pkg::REG_DN_THR:     dn_thr = value[lsfg_pkg::PCT_W-1:0];
                lsfg_pkg::REG_DN_FACTOR:  down_factor = value[lsfg_pkg::FACTOR_W-1:0];
                lsfg_pkg::REG_UP_WIN:     up_win = value[lsfg_pkg::UPWIN_W-1:0];
                lsfg_pkg::REG_DN_WIN:     dn_win = value[lsfg_pkg::DNWIN_W-1:0];
                lsfg_pkg::REG_FMAX:       fmax = value[lsfg_pkg::FREQ_W-1:0];
                lsfg_pkg::REG_FMIN:       fmin = value[lsfg_pkg::FREQ_W-1:0];
                lsfg_pkg::REG_COUNT_NICE: count_nice = value[0];
                default: ;
            endcase
        endfunction

        function void note_item(lsfg_pkg::t_action act, logic [lsfg_pkg::CNT_W-1:0] idle_c,
                                logic [lsfg_pkg::CNT_W-1:0] iow_c,
                                logic [lsfg_pkg::CNT_W-1:0] nice_c, logic slp,
                                logic [lsfg_pkg::FREQ_W-1:0] freq);
            logic [lsfg_pkg::CNT_W-1:0] total;
            logic [lsfg_pkg::CNT_W-1:0] delta;
            logic [63:0]                idle1;
            logic [63:0]                idle2;
            logic [63:0]                step;
            logic [63:0]                req;
            total = idle_c + iow_c + (count_nice ? nice_c : '0);
            if (act == lsfg_pkg::ACT_START) begin
                if (!enabled && freq != '0) begin
                    base_up   = total;
                    base_down = total;
                    enabled   = 1'b1;
                    skip      = '0;
                    requested = freq;
                end
                return;
            end
            if (act == lsfg_pkg::ACT_STOP) begin
                enabled = 1'b0;
                return;
            end
            if (!enabled) return;
            if (act == lsfg_pkg::ACT_NOTICE) begin
                requested = freq;
                return;
            end
            delta   = total - base_up;
            base_up = total;
            idle1   = 64'(delta) * 64'd100;
            if (idle1 < margin(up_thr) * 64'(up_win)) begin
                skip      = '0;
                base_down = base_up;
                if (requested == fmax && !slp) return;
                step = slp ? (64'(fmax) * 64'd20) / 64'd100 : 64'(fmax);
                if (step == 64'd0) step = 64'(lsfg_pkg::MIN_STEP_KHZ);
                req = 64'(requested) + step;
                if (req > 64'(fmax)) req = 64'(fmax);
                if (slp && req > 64'(lsfg_pkg::SLEEP_MAX_KHZ)) req = 64'(lsfg_pkg::SLEEP_MAX_KHZ);
                if (!slp && req < 64'(lsfg_pkg::AWAKE_MIN_KHZ)) req = 64'(lsfg_pkg::AWAKE_MIN_KHZ);
                requested = req[lsfg_pkg::FREQ_W-1:0];
                pending_targets.push_back('{requested, 1'b1});
                return;
            end
            skip = skip + 1'b1;
            if (skip < down_factor) return;
            delta     = base_up - base_down;
            base_down = base_up;
            idle2     = (64'(delta) < idle1) ? 64'(delta) : idle1;
            idle2     = idle2 * 64'd100;
            skip      = '0;
            if (idle2 <= margin(dn_thr) * 64'(dn_win)) return;
            if (requested == fmin && slp) return;
            if (64'(lsfg_pkg::STEP_DOWN_KHZ) > 64'(requested))
                req = 64'(fmin);
            else
                req = 64'(requested) - 64'(lsfg_pkg::STEP_DOWN_KHZ);
            if (req < 64'(fmin)) req = 64'(fmin);
            if (!slp && req < 64'(lsfg_pkg::AWAKE_MIN_KHZ)) req = 64'(lsfg_pkg::AWAKE_MIN_KHZ);
            if (slp && req > 64'(lsfg_pkg::SLEEP_MAX_KHZ)) req = 64'(lsfg_pkg::SLEEP_MAX_KHZ);
            requested = req[lsfg_pkg::FREQ_W-1:0];
            pending_targets.push_back('{requested, 1'b0});
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < 100) $display("mismatch: %s", msg);
            mismatch_count++;
        endtask

        task check_target(logic [lsfg_pkg::FREQ_W-1:0] got_khz, logic got_up);
            t_target_item want;
            if (pending_targets.size() == 0) begin
                report_mismatch($sformatf("unexpected target %0d went_up %0b",
                                          got_khz, got_up));
                return;
            end
            want = pending_targets.pop_front();
            if (got_khz !== want.target_khz)
                report_mismatch($sformatf("target_khz %0d, want %0d", got_khz, want.target_khz));
            if (got_up !== want.went_up)
                report_mismatch($sformatf("went_up %0b, want %0b", got_up, want.went_up));
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lsfg_pkg::APB_A_W-1:0]  paddr;
    logic [lsfg_pkg::APB_D_W-1:0]  pwdata;
    logic [lsfg_pkg::APB_D_W-1:0]  prdata;
    logic                          pready;
    logic [lsfg_pkg::CNT_W-1:0]    cnt_idle;
    logic [lsfg_pkg::CNT_W-1:0]    cnt_iow;
    logic [lsfg_pkg::CNT_W-1:0]    cnt_nice;
    int                            src_idle_pct = 25;
    int                            sink_idle_pct = 83;
    t_freq_target_board            board;

    lsfg_in_if  item_ch ();
    lsfg_out_if target_ch ();

    load_stepped_frequency_governor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .o_out   (target_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(negedge i_clk) begin
        target_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && target_ch.valid && target_ch.ready)
            board.check_target(target_ch.target_khz, target_ch.went_up);
    end

    task send_item(lsfg_pkg::t_action act, logic [lsfg_pkg::CNT_W-1:0] idle_c,
                   logic [lsfg_pkg::CNT_W-1:0] iow_c, logic [lsfg_pkg::CNT_W-1:0] nice_c,
                   logic slp, logic [lsfg_pkg::FREQ_W-1:0] freq);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.action       = act;
        item_ch.idle_count   = idle_c;
        item_ch.iowait_count = iow_c;
        item_ch.nice_count   = nice_c;
        item_ch.sleep_mode   = slp;
        item_ch.freq_khz     = freq;
        item_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        board.note_item(act, idle_c, iow_c, nice_c, slp, freq);
        @(negedge i_clk);
    endtask

    task send_counts(lsfg_pkg::t_action act, logic slp, logic [lsfg_pkg::FREQ_W-1:0] freq);
        send_item(act, cnt_idle, cnt_iow, cnt_nice, slp, freq);
    endtask

    task drain_targets();
        item_ch.valid = 1'b0;
        while (board.pending_targets.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task write_reg(lsfg_pkg::t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_register(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task apply_settings(int phase_idx);
        logic [31:0] vals [8];
        logic [31:0] up_pick;
        logic [31:0] fmax_pick;
        case (phase_idx)
            0: vals = '{50, 15, 4, 20, 80, 1000000, 245000, 1};
            1: vals = '{1, 0, 1, 1, 1, 0, 0, 0};
            2: vals = '{127, 127, 15, 65535, 1048575, 8388607, 8388607, 1};
            3: vals = '{60, 59, 0, 65535, 655350, 3, 8388607, 0};
            4: begin
                up_pick   = $urandom_range(1, 100);
                fmax_pick = $urandom_range(0, 8388607);
                vals = '{up_pick, $urandom_range(0, up_pick - 1), $urandom_range(1, 10),
                         $urandom_range(1, 65535), $urandom_range(1, 655350), fmax_pick,
                         $urandom_range(0, fmax_pick), $urandom_range(0, 1)};
            end
            default: begin
                foreach (vals[i]) vals[i] = $urandom;
            end
        endcase
        foreach (vals[i]) write_reg(lsfg_pkg::t_reg_idx'(i), vals[i]);
    endtask

    function logic [lsfg_pkg::FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 3))
            0: return lsfg_pkg::FREQ_W'($urandom);
            1: return board.fmin;
            2: return board.fmax;
            default: return lsfg_pkg::FREQ_W'($urandom_range(0, 1200000));
        endcase
    endfunction

    task send_random_item();
        int                         r;
        logic [63:0]                bnd;
        logic [lsfg_pkg::CNT_W-1:0] d;
        logic [lsfg_pkg::CNT_W-1:0] d_io;
        logic [lsfg_pkg::CNT_W-1:0] d_nice;
        r = $urandom_range(0, 99);
        if (!board.enabled && r < 90) begin
            if ($urandom_range(0, 3) == 0) begin
                cnt_idle = $urandom;
                cnt_iow  = $urandom;
                cnt_nice = $urandom;
            end
            send_counts(lsfg_pkg::ACT_START, 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 19) == 0) ? '0 : pick_freq());
        end else if (r < 4) begin
            send_counts(lsfg_pkg::ACT_STOP, 1'($urandom_range(0, 1)),
                        lsfg_pkg::FREQ_W'($urandom));
        end else if (r < 10) begin
            send_counts(lsfg_pkg::ACT_NOTICE, 1'($urandom_range(0, 1)), pick_freq());
        end else if (r < 15) begin
            cnt_idle = $urandom;
            cnt_iow  = $urandom;
            cnt_nice = $urandom;
            send_counts(lsfg_pkg::t_action'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        lsfg_pkg::FREQ_W'($urandom));
        end else begin
            bnd = (board.margin(board.up_thr) * 64'(board.up_win)
                   + board.margin(board.dn_thr) * 64'(board.dn_win)
                     / ((board.down_factor == '0) ? 64'd1 : 64'(board.down_factor))) / 64'd100;
            if ($urandom_range(0, 9) == 0)
                d = $urandom;
            else
                d = $urandom_range(0, 32'(2 * bnd + 3));
            d_io   = $urandom_range(0, d);
            d_nice = board.count_nice ? $urandom_range(0, d - d_io) : $urandom_range(0, 255);
            cnt_idle = cnt_idle + d - d_io - (board.count_nice ? d_nice : '0);
            cnt_iow  = cnt_iow + d_io;
            cnt_nice = cnt_nice + d_nice;
            send_counts(lsfg_pkg::ACT_SAMPLE, $urandom_range(0, 9) < 3,
                        lsfg_pkg::FREQ_W'($urandom));
        end
    endtask

    task run_directed();
        cnt_idle = 32'hFFFF_FFF0;
        cnt_iow  = '0;
        cnt_nice = '0;
        send_counts(lsfg_pkg::ACT_SAMPLE, 1'b0, 23'd123);
        send_counts(lsfg_pkg::ACT_NOTICE, 1'b0, 23'd555);
        send_counts(lsfg_pkg::ACT_START, 1'b0, '0);
        send_counts(lsfg_pkg::ACT_START, 1'b0, 23'd300000);
        send_counts(lsfg_pkg::ACT_START, 1'b0, '1);
        send_counts(lsfg_pkg::ACT_SAMPLE, 1'b0, '0);
        send_counts(lsfg_pkg::ACT_SAMPLE, 1'b0, '0);
        send_counts(lsfg_pkg::ACT_SAMPLE, 1'b1, '0);
        repeat (4) begin
            cnt_idle = cnt_idle + 32'd50;
            send_counts(lsfg_pkg::ACT_SAMPLE, 1'b0, '0);
        end
        send_counts(lsfg_pkg::ACT_NOTICE, 1'b0, lsfg_pkg::RST_FMIN);
        repeat (4) begin
            cnt_iow = cnt_iow + 32'd50;
            send_counts(lsfg_pkg::ACT_SAMPLE, 1'b1, '0);
        end
        send_counts(lsfg_pkg::ACT_NOTICE, 1'b0, 23'd100000);
        repeat (4) begin
            cnt_nice = cnt_nice + 32'd50;
            send_counts(lsfg_pkg::ACT_SAMPLE, 1'b1, '0);
        end
        send_counts(lsfg_pkg::ACT_STOP, 1'b0, '0);
        send_counts(lsfg_pkg::ACT_SAMPLE, 1'b0, '0);
        cnt_idle = '1;
        cnt_iow  = '1;
        cnt_nice = '1;
        send_counts(lsfg_pkg::ACT_START, 1'b1, '1);
    endtask

    initial begin
        board                = new();
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_ch.valid        = 1'b0;
        item_ch.action       = lsfg_pkg::ACT_SAMPLE;
        item_ch.idle_count   = '0;
        item_ch.iowait_count = '0;
        item_ch.nice_count   = '0;
        item_ch.sleep_mode   = 1'b0;
        item_ch.freq_khz     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
            case (phase_idx / 2)
                0: begin
                    src_idle_pct  = 25;
                    sink_idle_pct = 83;
                end
                1: begin
                    src_idle_pct  = 83;
                    sink_idle_pct = 25;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            drain_targets();
            apply_settings(phase_idx);
            for (int k = 0; k < 300; k++) begin
                if (k == 150 || $urandom_range(0, 99) == 0) drain_targets();
                send_random_item();
            end
        end
        item_ch.valid = 1'b0;
        while (board.pending_targets.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/lsfg_pkg.sv
src/lsfg_in_if.sv
src/lsfg_out_if.sv
src/load_stepped_frequency_governor_unit.sv
verif/tb.sv
